// ===== design/teq_pkg.sv =====
// ----------------------------------------------------------------------------
// Timed event queue package
// Shared payload types, operation and result codes, and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package teq_pkg;

    // Operation codes of an input item.
    localparam logic [1:0] FUNC_POST    = 2'd0;
    localparam logic [1:0] FUNC_CANCEL  = 2'd1;
    localparam logic [1:0] FUNC_ADVANCE = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_POST   = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_DUE    = 2'd2;
    localparam logic [1:0] KIND_TIME   = 2'd3;

    // Most events dispatched by one advance.
    localparam int MAX_RESULTS = 16;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] delay;
        logic [3:0]  task_req;
        logic [7:0]  event_req;
        logic [15:0] elapsed;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        ok;
        logic [3:0]  due_task;
        logic [7:0]  due_event;
        logic [15:0] time_left;
        logic        queue_empty;
        logic        last;
    } res_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_ALLOC,
        OP_HEAD_INS,
        OP_HEAD_WALK,
        OP_STEP_LINK,
        OP_ADV_CUR,
        OP_INS1,
        OP_INS2,
        OP_READ_CUR,
        OP_SKIP,
        OP_REL1,
        OP_REL2,
        OP_AGE,
        OP_REWALK,
        OP_READ_HEAD,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] kind;
        logic       ok;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       free_empty;
        logic       pend_empty;
        logic       cur_end;
        logic       link_end;
        logic       rec_gt;
        logic       match;
        logic       rec_zero;
        logic       due_none;
        logic       walk_done;
        logic       out_free;
    } dp_status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_P_START,
        ST_P_HEAD,
        ST_P_LINK,
        ST_P_REC,
        ST_P_INS1,
        ST_P_INS2,
        ST_C_CHK,
        ST_C_EVAL,
        ST_REL1,
        ST_REL2,
        ST_A1_CHK,
        ST_A1_EVAL,
        ST_A2_START,
        ST_A_TIME,
        ST_A2_CHK,
        ST_A2_EVAL,
        ST_RESP_OK,
        ST_RESP_FAIL
    } state_t;

endpackage

// ===== design/teq_dp.sv =====
// ----------------------------------------------------------------------------
// Timed event queue datapath
// Slot memories, linked-list pointers, walk counters and the result register.
// ----------------------------------------------------------------------------
module teq_dp import teq_pkg::*; #(
    parameter int DEPTH     = 16,
    parameter int TIME_BITS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  dp_cmd_t    cmd,
    input  req_t       s_item,
    output dp_status_t status,
    output logic       m_valid,
    input  logic       m_ready,
    output res_t       m_item
);

    localparam int IW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam logic [LW-1:0] END_MARK = LW'(DEPTH);

    logic [1:0]           func_reg, func_next;
    logic [TIME_BITS-1:0] dly_reg, dly_next;
    logic [3:0]           tsk_reg, tsk_next;
    logic [7:0]           code_reg, code_next;
    logic [TIME_BITS-1:0] el_reg, el_next;

    logic [LW-1:0] free_head_reg, free_head_next;
    logic [LW-1:0] pend_head_reg, pend_head_next;
    logic [LW-1:0] cur_reg, cur_next;
    logic [LW-1:0] prev_reg, prev_next;
    logic [LW-1:0] nxt_reg, nxt_next;
    logic [LW-1:0] slot_reg, slot_next;
    logic [LW-1:0] pend_cnt_reg, pend_cnt_next;
    logic [LW-1:0] due_cnt_reg, due_cnt_next;
    logic [LW-1:0] n_reg, n_next;
    res_t          out_reg, out_next;
    logic          out_vld_reg, out_vld_next;

    logic [TIME_BITS-1:0] dly_mem [DEPTH];
    logic [3:0]           tsk_mem [DEPTH];
    logic [7:0]           code_mem [DEPTH];
    logic [LW-1:0]        link_mem [DEPTH];
    logic [DEPTH-1:0]     link_vld_reg;

    logic [TIME_BITS-1:0] rd_dly_reg;
    logic [3:0]           rd_tsk_reg;
    logic [7:0]           rd_code_reg;
    logic [LW-1:0]        link_rd_reg;

    logic                 rec_re, rec_we, link_re, link_we;
    logic [LW-1:0]        rec_ra, rec_wa, link_ra, link_wa, link_wd;
    logic [TIME_BITS-1:0] rec_wd_dly, new_dly;
    logic [3:0]           rec_wd_tsk;
    logic [7:0]           rec_wd_code;
    logic [LW-1:0]        disp;

    assign new_dly = (rd_dly_reg > el_reg) ? rd_dly_reg - el_reg : '0;
    // Events this advance dispatches, capped per advance.
    assign disp = (int'(due_cnt_reg) > MAX_RESULTS) ? LW'(MAX_RESULTS) : due_cnt_reg;

    always_comb begin
        func_next      = func_reg;
        dly_next       = dly_reg;
        tsk_next       = tsk_reg;
        code_next      = code_reg;
        el_next        = el_reg;
        free_head_next = free_head_reg;
        pend_head_next = pend_head_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        nxt_next       = nxt_reg;
        slot_next      = slot_reg;
        pend_cnt_next  = pend_cnt_reg;
        due_cnt_next   = due_cnt_reg;
        n_next         = n_reg;
        out_next       = out_reg;
        out_vld_next   = out_vld_reg && !m_ready;
        rec_re         = 1'b0;
        rec_ra         = cur_reg;
        rec_we         = 1'b0;
        rec_wa         = cur_reg;
        rec_wd_dly     = new_dly;
        rec_wd_tsk     = rd_tsk_reg;
        rec_wd_code    = rd_code_reg;
        link_re        = 1'b0;
        link_ra        = cur_reg;
        link_we        = 1'b0;
        link_wa        = cur_reg;
        link_wd        = free_head_reg;
        case (cmd.op)
            OP_LOAD: begin
                func_next     = s_item.func;
                dly_next      = TIME_BITS'(s_item.delay);
                tsk_next      = s_item.task_req;
                code_next     = s_item.event_req;
                el_next       = TIME_BITS'(s_item.elapsed);
                cur_next      = pend_head_reg;
                prev_next     = END_MARK;
                pend_cnt_next = '0;
                due_cnt_next  = '0;
                n_next        = '0;
            end
            OP_ALLOC: begin
                slot_next   = free_head_reg;
                link_re     = 1'b1;
                link_ra     = free_head_reg;
                rec_re      = 1'b1;
                rec_ra      = pend_head_reg;
                rec_we      = 1'b1;
                rec_wa      = free_head_reg;
                rec_wd_dly  = dly_reg;
                rec_wd_tsk  = tsk_reg;
                rec_wd_code = code_reg;
            end
            OP_HEAD_INS: begin
                free_head_next = link_rd_reg;
                link_we        = 1'b1;
                link_wa        = slot_reg;
                link_wd        = pend_head_reg;
                pend_head_next = slot_reg;
            end
            OP_HEAD_WALK: begin
                free_head_next = link_rd_reg;
                cur_next       = pend_head_reg;
                link_re        = 1'b1;
                link_ra        = pend_head_reg;
            end
            OP_STEP_LINK: begin
                nxt_next = link_rd_reg;
                rec_re   = 1'b1;
                rec_ra   = link_rd_reg;
            end
            OP_ADV_CUR: begin
                cur_next = nxt_reg;
                link_re  = 1'b1;
                link_ra  = nxt_reg;
            end
            OP_INS1: begin
                link_we = 1'b1;
                link_wa = slot_reg;
                link_wd = nxt_reg;
            end
            OP_INS2: begin
                link_we = 1'b1;
                link_wa = cur_reg;
                link_wd = slot_reg;
            end
            OP_READ_CUR: begin
                rec_re  = 1'b1;
                link_re = 1'b1;
            end
            OP_SKIP: begin
                prev_next = cur_reg;
                cur_next  = link_rd_reg;
            end
            OP_REL1: begin
                if (prev_reg == END_MARK) begin
                    pend_head_next = link_rd_reg;
                end else begin
                    link_we = 1'b1;
                    link_wa = prev_reg;
                    link_wd = link_rd_reg;
                end
            end
            OP_REL2: begin
                link_we        = 1'b1;
                free_head_next = cur_reg;
                cur_next       = link_rd_reg;
            end
            OP_AGE: begin
                rec_we        = 1'b1;
                pend_cnt_next = LW'(pend_cnt_reg + 1'b1);
                if (new_dly == '0) begin
                    due_cnt_next = LW'(due_cnt_reg + 1'b1);
                end
                cur_next = link_rd_reg;
            end
            OP_REWALK: begin
                cur_next  = pend_head_reg;
                prev_next = END_MARK;
                n_next    = '0;
            end
            OP_READ_HEAD: begin
                rec_re = 1'b1;
                rec_ra = pend_head_reg;
            end
            OP_EMIT: begin
                out_vld_next      = 1'b1;
                out_next.kind     = cmd.kind;
                out_next.ok       = cmd.ok;
                out_next.due_task  = (cmd.kind == KIND_DUE) ? rd_tsk_reg : '0;
                out_next.due_event = (cmd.kind == KIND_DUE) ? rd_code_reg : '0;
                out_next.time_left =
                    (cmd.kind == KIND_TIME && pend_head_reg != END_MARK) ?
                    16'(rd_dly_reg) : '0;
                if (cmd.kind == KIND_DUE) begin
                    out_next.queue_empty = (pend_cnt_reg == disp);
                    out_next.last        = (LW'(n_reg + 1'b1) == disp);
                    n_next               = LW'(n_reg + 1'b1);
                end else begin
                    out_next.queue_empty = (pend_head_reg == END_MARK);
                    out_next.last        = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_head_reg <= '0;
            pend_head_reg <= END_MARK;
            out_vld_reg   <= 1'b0;
        end else begin
            free_head_reg <= free_head_next;
            pend_head_reg <= pend_head_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg     <= func_next;
        dly_reg      <= dly_next;
        tsk_reg      <= tsk_next;
        code_reg     <= code_next;
        el_reg       <= el_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        nxt_reg      <= nxt_next;
        slot_reg     <= slot_next;
        pend_cnt_reg <= pend_cnt_next;
        due_cnt_reg  <= due_cnt_next;
        n_reg        <= n_next;
        out_reg      <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (rec_we) begin
            dly_mem[rec_wa[IW-1:0]]  <= rec_wd_dly;
            tsk_mem[rec_wa[IW-1:0]]  <= rec_wd_tsk;
            code_mem[rec_wa[IW-1:0]] <= rec_wd_code;
        end
        if (rec_re) begin
            rd_dly_reg  <= dly_mem[rec_ra[IW-1:0]];
            rd_tsk_reg  <= tsk_mem[rec_ra[IW-1:0]];
            rd_code_reg <= code_mem[rec_ra[IW-1:0]];
        end
    end

    // A link entry never written reads as its index plus one, through its link valid bit.
    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_wa[IW-1:0]] <= link_wd;
        end
        if (link_re) begin
            link_rd_reg <= link_vld_reg[link_ra[IW-1:0]] ? link_mem[link_ra[IW-1:0]] :
                           LW'(link_ra[IW-1:0]) + LW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_vld_reg <= '0;
        end else if (link_we) begin
            link_vld_reg[link_wa[IW-1:0]] <= 1'b1;
        end
    end

    assign status.func       = func_reg;
    assign status.free_empty = (free_head_reg == END_MARK);
    assign status.pend_empty = (pend_head_reg == END_MARK);
    assign status.cur_end    = (cur_reg == END_MARK);
    assign status.link_end   = (link_rd_reg == END_MARK);
    assign status.rec_gt     = (rd_dly_reg > dly_reg);
    assign status.match      = (rd_tsk_reg == tsk_reg) && (rd_code_reg == code_reg);
    assign status.rec_zero   = (rd_dly_reg == '0);
    assign status.due_none   = (due_cnt_reg == '0);
    assign status.walk_done  = (n_reg == disp);
    assign status.out_free   = !out_vld_reg || m_ready;

    assign m_valid = out_vld_reg;
    assign m_item  = out_reg;

endmodule

// ===== design/teq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Timed event queue controller
// Sequences the list walks of post, cancel and advance over the datapath.
// ----------------------------------------------------------------------------
module teq_ctrl import teq_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_func,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '{op: OP_NOP, kind: KIND_POST, ok: 1'b0};
        s_ready    = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                // The operation code is taken from the input while loading.
                if (s_valid) begin
                    cmd.op = OP_LOAD;
                    case (s_func)
                        FUNC_POST: begin
                            state_next = ST_P_START;
                        end
                        FUNC_CANCEL: begin
                            state_next = ST_C_CHK;
                        end
                        FUNC_ADVANCE: begin
                            state_next = ST_A1_CHK;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_P_START: begin
                if (status.free_empty) begin
                    state_next = ST_RESP_FAIL;
                end else begin
                    cmd.op     = OP_ALLOC;
                    state_next = ST_P_HEAD;
                end
            end
            ST_P_HEAD: begin
                if (status.pend_empty || status.rec_gt) begin
                    cmd.op     = OP_HEAD_INS;
                    state_next = ST_RESP_OK;
                end else begin
                    cmd.op     = OP_HEAD_WALK;
                    state_next = ST_P_LINK;
                end
            end
            ST_P_LINK: begin
                cmd.op     = OP_STEP_LINK;
                state_next = status.link_end ? ST_P_INS1 : ST_P_REC;
            end
            ST_P_REC: begin
                if (status.rec_gt) begin
                    cmd.op     = OP_INS1;
                    state_next = ST_P_INS2;
                end else begin
                    cmd.op     = OP_ADV_CUR;
                    state_next = ST_P_LINK;
                end
            end
            ST_P_INS1: begin
                cmd.op     = OP_INS1;
                state_next = ST_P_INS2;
            end
            ST_P_INS2: begin
                cmd.op     = OP_INS2;
                state_next = ST_RESP_OK;
            end
            ST_C_CHK: begin
                if (status.cur_end) begin
                    state_next = ST_RESP_FAIL;
                end else begin
                    cmd.op     = OP_READ_CUR;
                    state_next = ST_C_EVAL;
                end
            end
            ST_C_EVAL: begin
                if (status.match) begin
                    state_next = ST_REL1;
                end else begin
                    cmd.op     = OP_SKIP;
                    state_next = ST_C_CHK;
                end
            end
            ST_REL1: begin
                cmd.op     = OP_REL1;
                state_next = ST_REL2;
            end
            ST_REL2: begin
                cmd.op     = OP_REL2;
                state_next = (status.func == FUNC_CANCEL) ? ST_RESP_OK : ST_A2_CHK;
            end
            ST_A1_CHK: begin
                if (status.cur_end) begin
                    state_next = ST_A2_START;
                end else begin
                    cmd.op     = OP_READ_CUR;
                    state_next = ST_A1_EVAL;
                end
            end
            ST_A1_EVAL: begin
                cmd.op     = OP_AGE;
                state_next = ST_A1_CHK;
            end
            ST_A2_START: begin
                if (status.due_none) begin
                    cmd.op     = OP_READ_HEAD;
                    state_next = ST_A_TIME;
                end else begin
                    cmd.op     = OP_REWALK;
                    state_next = ST_A2_CHK;
                end
            end
            ST_A_TIME: begin
                if (status.out_free) begin
                    cmd.op     = OP_EMIT;
                    cmd.kind   = KIND_TIME;
                    state_next = ST_IDLE;
                end
            end
            ST_A2_CHK: begin
                if (status.cur_end || status.walk_done) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.op     = OP_READ_CUR;
                    state_next = ST_A2_EVAL;
                end
            end
            ST_A2_EVAL: begin
                if (!status.rec_zero) begin
                    cmd.op     = OP_SKIP;
                    state_next = ST_A2_CHK;
                end else if (status.out_free) begin
                    cmd.op     = OP_EMIT;
                    cmd.kind   = KIND_DUE;
                    state_next = ST_REL1;
                end
            end
            ST_RESP_OK: begin
                if (status.out_free) begin
                    cmd.op     = OP_EMIT;
                    cmd.kind   = status.func;
                    cmd.ok     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RESP_FAIL: begin
                if (status.out_free) begin
                    cmd.op     = OP_EMIT;
                    cmd.kind   = status.func;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/timed_event_queue.sv =====
// ----------------------------------------------------------------------------
// Timed event queue
// Time-ordered list of pending events in a slot pool with a linked free list.
// ----------------------------------------------------------------------------
// Usage: an input item on the s_ channel carries an operation. A post takes a
// free slot and links the event in after every pending event whose delay is
// equal or smaller; a full pool answers with ok low. A cancel removes the
// first pending event that matches both task and event code. An advance ages
// every pending delay by the elapsed ticks, saturating at zero, then
// dispatches the due events in list order, at most sixteen per advance, or
// reports the head delay when nothing is due. Operation code 3 is ignored.
// Results leave on the m_ channel; the last result of an item has last high.
// Throughput: one item at a time. A post and a cancel walk the list entry by
// entry; an advance ages every pending event, then scans the list again and
// dispatches the due events. Each walk step reads the slot and link memories
// through their one registered read port.
// A new item is taken only in the idle state, while an earlier result may
// still wait in the output register. If the receiver stalls, the walk halts
// at the next result until the output register frees up.
// Reset: synchronous, active low. It empties the pending list and chains all
// slots into the free list at once through per-entry link valid bits, so the
// block takes items as soon as reset is released, with no clearing pass.
// ----------------------------------------------------------------------------
module timed_event_queue import teq_pkg::*; #(
    parameter int DEPTH     = 16,
    parameter int TIME_BITS = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_item,
    output logic m_valid,
    input  logic m_ready,
    output res_t m_item
);

    dp_cmd_t    cmd;
    dp_status_t status;
    dp_cmd_t    ctl_cmd;
    state_t     start_state;

    // The controller decides the work; the datapath owns all storage.
    teq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_item.func),
        .status  (status),
        .cmd     (ctl_cmd)
    );

    assign cmd = ctl_cmd;

    teq_dp #(
        .DEPTH     (DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_item  (s_item),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // Starting state that follows a load; checked below for the ignored code.
    always_comb begin
        case (s_item.func)
            FUNC_POST:    start_state = ST_P_START;
            FUNC_CANCEL:  start_state = ST_C_CHK;
            FUNC_ADVANCE: start_state = ST_A1_CHK;
            default:      start_state = ST_IDLE;
        endcase
    end

    // Post, cancel and time reports are always the single result of an item.
    a_single_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.kind != KIND_DUE |-> m_item.last)
        else $error("non-dispatch result without last");

    // A post, accepted or rejected, always leaves at least one event pending.
    a_post_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.kind == KIND_POST |-> !m_item.queue_empty)
        else $error("post result reports an empty queue");

    // Every slot is pending or free, so both lists are never empty together.
    a_pool_conserved: assert property (@(posedge aclk) disable iff (!aresetn)
        !(status.free_empty && status.pend_empty))
        else $error("slot pool lost track of its slots");

    // A new result is loaded only when the output register can take it.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_EMIT |-> status.out_free)
        else $error("result register overwritten while stalled");

    // Unused by the datapath, kept for the dispatch check on a valid load.
    a_dispatch_func: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && start_state == ST_IDLE |=> s_ready)
        else $error("ignored operation left the idle state");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timed event queue testbench
// Drives post, cancel, advance and unused items with random gaps, predicts
// every result from a behavioral copy of the slot pool and checks each field.
// ----------------------------------------------------------------------------
module tb;
    import teq_pkg::*;

    localparam int NSLOT = 16;
    localparam int WATCH_LIMIT = 20000;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_item = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    res_t m_item;

    timed_event_queue u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Behavioral copy of the slot pool.
    logic [15:0] pool_delay [NSLOT];
    logic [3:0]  pool_task [NSLOT];
    logic [7:0]  pool_code [NSLOT];
    int          pool_link [NSLOT];
    int          free_top;
    int          pend_top;

    req_t pending_items [$];
    res_t expected_results [$];
    int   error_count = 0;
    int   idle_cycles = 0;
    bit   hold_for_drain = 1'b0;

    task automatic report(input string what);
        error_count++;
        $display("mismatch: %s", what);
    endtask

    function automatic void unlink_slot(input int prev, input int idx);
        if (prev >= NSLOT) begin
            pend_top = pool_link[idx];
        end else begin
            pool_link[prev] = pool_link[idx];
        end
        pool_link[idx] = free_top;
        free_top = idx;
    endfunction

    function automatic res_t make_res(input logic [1:0] k, input logic okv,
                                      input logic [3:0] t, input logic [7:0] c,
                                      input logic [15:0] tl);
        res_t r;
        r = '0;
        r.kind = k; r.ok = okv; r.due_task = t; r.due_event = c; r.time_left = tl;
        return r;
    endfunction

    // Works out the results of one item and queues them in order.
    function automatic void predict_queue(input req_t it);
        res_t outs [$];
        int slot, idx, prev, nxt, g;
        bit hit;
        outs = {};
        if (it.func == FUNC_POST) begin
            if (free_top >= NSLOT) begin
                outs.push_back(make_res(KIND_POST, 1'b0, 0, 0, 0));
            end else begin
                slot = free_top;
                free_top = pool_link[slot];
                pool_delay[slot] = it.delay;
                pool_task[slot] = it.task_req;
                pool_code[slot] = it.event_req;
                if (pend_top >= NSLOT || pool_delay[pend_top] > it.delay) begin
                    pool_link[slot] = pend_top;
                    pend_top = slot;
                end else begin
                    idx = pend_top;
                    for (g = 0; g < NSLOT; g++) begin
                        nxt = pool_link[idx];
                        if (nxt >= NSLOT || pool_delay[nxt] > it.delay) break;
                        idx = nxt;
                    end
                    pool_link[slot] = pool_link[idx];
                    pool_link[idx] = slot;
                end
                outs.push_back(make_res(KIND_POST, 1'b1, 0, 0, 0));
            end
        end else if (it.func == FUNC_CANCEL) begin
            hit = 1'b0;
            prev = NSLOT;
            idx = pend_top;
            for (g = 0; g < NSLOT && idx < NSLOT; g++) begin
                if (pool_task[idx] == it.task_req && pool_code[idx] == it.event_req) begin
                    unlink_slot(prev, idx);
                    hit = 1'b1;
                    break;
                end
                prev = idx;
                idx = pool_link[idx];
            end
            outs.push_back(make_res(KIND_CANCEL, hit, 0, 0, 0));
        end else if (it.func == FUNC_ADVANCE) begin
            idx = pend_top;
            for (g = 0; g < NSLOT && idx < NSLOT; g++) begin
                pool_delay[idx] = (pool_delay[idx] > it.elapsed) ?
                                  pool_delay[idx] - it.elapsed : 16'd0;
                idx = pool_link[idx];
            end
            idx = pend_top;
            prev = NSLOT;
            for (g = 0; g < NSLOT && idx < NSLOT && outs.size() < MAX_RESULTS; g++) begin
                nxt = pool_link[idx];
                if (pool_delay[idx] == 0) begin
                    outs.push_back(make_res(KIND_DUE, 1'b0, pool_task[idx],
                                            pool_code[idx], 0));
                    unlink_slot(prev, idx);
                end else begin
                    prev = idx;
                end
                idx = nxt;
            end
            if (outs.size() == 0)
                outs.push_back(make_res(KIND_TIME, 1'b0, 0, 0,
                                        pend_top < NSLOT ? pool_delay[pend_top] : 16'd0));
        end
        foreach (outs[k]) begin
            outs[k].queue_empty = (pend_top >= NSLOT);
            outs[k].last = (k == outs.size() - 1);
            expected_results.push_back(outs[k]);
        end
    endfunction

    function automatic req_t make_req(input logic [1:0] f, input logic [15:0] d,
                                      input logic [3:0] t, input logic [7:0] c,
                                      input logic [15:0] e);
        req_t r;
        r.func = f; r.delay = d; r.task_req = t; r.event_req = c; r.elapsed = e;
        return r;
    endfunction

    // Driver: one item at a time from the pending queue, with random gaps.
    int gap_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_queue(s_item);
                gap_left <= $urandom_range(0, 8);
                if (gap_left == 0 && pending_items.size() > 0 && !hold_for_drain
                    && $urandom_range(0, 8) == 0) begin
                    s_valid <= 1'b0;
                end else begin
                    s_valid <= 1'b0;
                end
            end else if (!s_valid) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (pending_items.size() > 0 &&
                             !(hold_for_drain && expected_results.size() > 0)) begin
                    s_item <= pending_items.pop_front();
                    s_valid <= 1'b1;
                end
            end
        end
    end

    // Monitor: compares each accepted result with the oldest expectation.
    int stall_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report("result with nothing expected");
                end else begin
                    res_t want;
                    want = expected_results.pop_front();
                    if (m_item.kind != want.kind) report("kind");
                    if (m_item.ok != want.ok) report("ok");
                    if (m_item.due_task != want.due_task) report("due_task");
                    if (m_item.due_event != want.due_event) report("due_event");
                    if (m_item.time_left != want.time_left) report("time_left");
                    if (m_item.queue_empty != want.queue_empty) report("queue_empty");
                    if (m_item.last != want.last) report("last");
                end
                stall_left <= $urandom_range(0, 8);
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
            // Watchdog on cycles without any handshake.
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // Random item with a bias toward tasks and codes that already exist.
    function automatic req_t random_req();
        int sel;
        logic [15:0] d, e;
        sel = $urandom_range(0, 99);
        d = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        e = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30));
        if (sel < 45)
            return make_req(FUNC_POST, d, 4'($urandom_range(0, 3)),
                            ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                            8'($urandom_range(0, 3)), 16'($urandom));
        else if (sel < 62)
            return make_req(FUNC_CANCEL, 16'($urandom), 4'($urandom_range(0, 3)),
                            8'($urandom_range(0, 3)), 16'($urandom));
        else if (sel < 96)
            return make_req(FUNC_ADVANCE, 16'($urandom), 4'($urandom), 8'($urandom), e);
        else
            return make_req(FUNC_UNUSED, 16'($urandom), 4'($urandom), 8'($urandom),
                            16'($urandom));
    endfunction

    initial begin
        for (int i = 0; i < NSLOT; i++) begin
            pool_delay[i] = '0; pool_task[i] = '0; pool_code[i] = '0;
            pool_link[i] = i + 1;
        end
        free_top = 0;
        pend_top = NSLOT;

        // Directed part: empty advance, empty list post, bit extremes,
        // full pool, cancel miss and hit, many due at once, unused code.
        pending_items.push_back(make_req(FUNC_ADVANCE, 16'hFFFF, 4'hF, 8'hFF, 16'h0000));
        pending_items.push_back(make_req(FUNC_POST, 16'hFFFF, 4'hF, 8'hFF, 16'hFFFF));
        pending_items.push_back(make_req(FUNC_POST, 16'h0000, 4'h0, 8'h00, 16'h0000));
        for (int i = 0; i < 15; i++)
            pending_items.push_back(make_req(FUNC_POST, 16'(i % 3), 4'(i), 8'(i), 16'h0));
        pending_items.push_back(make_req(FUNC_CANCEL, 16'h0, 4'h9, 8'hAA, 16'h0));
        pending_items.push_back(make_req(FUNC_CANCEL, 16'h0, 4'hF, 8'hFF, 16'h0));
        pending_items.push_back(make_req(FUNC_UNUSED, 16'hFFFF, 4'hF, 8'hFF, 16'hFFFF));
        pending_items.push_back(make_req(FUNC_ADVANCE, 16'h0, 4'h0, 8'h0, 16'h0001));
        pending_items.push_back(make_req(FUNC_ADVANCE, 16'h0, 4'h0, 8'h0, 16'h0000));
        pending_items.push_back(make_req(FUNC_ADVANCE, 16'h0, 4'h0, 8'h0, 16'hFFFF));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < 48; i++) pending_items.push_back(random_req());
        // Second batch: each item waits until all earlier results have drained.
        wait (pending_items.size() == 0);
        hold_for_drain = 1'b1;
        for (int i = 0; i < 48; i++) pending_items.push_back(random_req());
        wait (expected_results.size() == 0 && !s_valid);
        @(posedge aclk);
        hold_for_drain = 1'b0;
        wait (pending_items.size() == 0 && !s_valid);
        wait (expected_results.size() == 0);
        repeat (100) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        wait (idle_cycles >= WATCH_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
